/* rtl/cfse_pkg.sv */
// ----------------------------------------------------------------------------
// cfse_pkg: shared types and constants of the color frame symbol encoder
// Region geometry, header layout, the command item passed from the front to
// the back, and small lookup functions.
// ----------------------------------------------------------------------------
package cfse_pkg;

	localparam int FRAME_BYTES_MAX = 3738;
	localparam int CMD_QUEUE_DEPTH = 2;

	localparam int          NUM_REGIONS = 7;
	localparam logic [6:0]  HEADER_ROW  = 7'd18;
	localparam logic [6:0]  HEADER_COL  = 7'd2;
	localparam logic [2:0]  COLOR_BLACK = 3'd0;
	localparam logic [2:0]  COLOR_WHITE = 3'd7;

	// frame kind codes
	localparam logic [1:0] KIND_START     = 2'd0;
	localparam logic [1:0] KIND_END       = 2'd1;
	localparam logic [1:0] KIND_START_END = 2'd2;
	localparam logic [1:0] KIND_NORMAL    = 2'd3;

	// one queued command: an optional group of eight cells and an optional header
	typedef struct packed {
		logic        has_group;
		logic        has_header;
		logic [23:0] code;
		logic [6:0]  row;
		logic [6:0]  col;
		logic [1:0]  kind;
		logic [11:0] len;
		logic [15:0] cks;
		logic [7:0]  fnum;
		logic        ovf;
	} cfse_cmd_t;

	function automatic logic [6:0] reg_rows(input logic [2:0] r);
		logic [6:0] v;
		unique case (r)
			3'd0:    v = 7'd71;
			3'd1:    v = 7'd16;
			3'd2:    v = 7'd72;
			3'd3:    v = 7'd72;
			3'd4:    v = 7'd16;
			3'd5:    v = 7'd8;
			3'd6:    v = 7'd8;
			default: v = 7'd0;
		endcase
		return v;
	endfunction

	function automatic logic [3:0] reg_groups(input logic [2:0] r);
		logic [3:0] v;
		unique case (r)
			3'd0:    v = 4'd2;
			3'd1:    v = 4'd9;
			3'd2:    v = 4'd9;
			3'd3:    v = 4'd2;
			3'd4:    v = 4'd9;
			3'd5:    v = 4'd2;
			3'd6:    v = 4'd1;
			default: v = 4'd0;
		endcase
		return v;
	endfunction

	function automatic logic [6:0] reg_row0(input logic [2:0] r);
		logic [6:0] v;
		unique case (r)
			3'd0:    v = 7'd19;
			3'd1:    v = 7'd2;
			3'd2:    v = 7'd18;
			3'd3:    v = 7'd18;
			3'd4:    v = 7'd90;
			3'd5:    v = 7'd90;
			3'd6:    v = 7'd98;
			default: v = 7'd0;
		endcase
		return v;
	endfunction

	function automatic logic [6:0] reg_col0(input logic [2:0] r);
		logic [6:0] v;
		unique case (r)
			3'd0:    v = 7'd2;
			3'd1:    v = 7'd18;
			3'd2:    v = 7'd18;
			3'd3:    v = 7'd90;
			3'd4:    v = 7'd18;
			3'd5:    v = 7'd90;
			3'd6:    v = 7'd90;
			default: v = 7'd0;
		endcase
		return v;
	endfunction

	// frame-kind flag cells, four per kind
	function automatic logic [2:0] flag_color(input logic [1:0] kind, input logic [1:0] idx);
		logic [2:0] v;
		unique case (kind)
			KIND_START:     v = idx[1] ? COLOR_BLACK : COLOR_WHITE;
			KIND_END:       v = idx[1] ? COLOR_WHITE : COLOR_BLACK;
			KIND_START_END: v = COLOR_WHITE;
			KIND_NORMAL:    v = COLOR_BLACK;
			default:        v = COLOR_BLACK;
		endcase
		return v;
	endfunction

endpackage

/* rtl/cfse_front.sv */
// ----------------------------------------------------------------------------
// cfse_front: byte intake and group classification
// Packs bytes into groups, keeps checksum and region position, and issues one
// command per item that causes cell writes.
// ----------------------------------------------------------------------------
module cfse_front import cfse_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_MAX
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [1:0] frame_kind,
	input  logic [7:0] frame_number,
	input  logic       q_full,
	output logic       q_push,
	output cfse_cmd_t  q_cmd
);

	localparam logic [11:0] FB = 12'(FRAME_BYTES);

	logic [11:0] count_q, count_n;
	logic [1:0]  pos_q, pos_n;
	logic [15:0] hold_q, hold_n;
	logic [15:0] cks_q, cks_n;
	logic [2:0]  region_q, region_n;
	logic [6:0]  row_q, row_n;
	logic [3:0]  grp_q, grp_n;
	logic        ovf_q, ovf_n;
	logic        acc, take, grp_full, pad, emit;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		take     = count_q < FB;
		count_n  = count_q;
		pos_n    = pos_q;
		hold_n   = hold_q;
		cks_n    = cks_q;
		ovf_n    = ovf_q | !take;
		if (take) begin
			count_n = count_q + 12'd1;
			pos_n   = (pos_q == 2'd2) ? 2'd0 : pos_q + 2'd1;
			cks_n   = cks_q ^ (count_q[0] ? {8'h00, data_byte} : {data_byte, 8'h00});
			case (pos_q)
				2'd0:    hold_n = {data_byte, 8'h00};
				2'd1:    hold_n = {hold_q[15:8], data_byte};
				default: hold_n = 16'h0000;
			endcase
		end
		grp_full = take && (pos_q == 2'd2);
		pad      = last_byte && (pos_n != 2'd0);
		emit     = (grp_full || pad) && (region_q < 3'(NUM_REGIONS));

		// advance region position after a written group
		region_n = region_q;
		row_n    = row_q;
		grp_n    = grp_q;
		if (emit) begin
			grp_n = grp_q + 4'd1;
			if (grp_n >= reg_groups(region_q)) begin
				grp_n = 4'd0;
				row_n = row_q + 7'd1;
				if (row_n >= reg_rows(region_q)) begin
					row_n    = 7'd0;
					region_n = region_q + 3'd1;
				end
			end
		end

		q_cmd.has_group  = emit;
		q_cmd.has_header = last_byte;
		q_cmd.code       = grp_full ? {hold_q, data_byte} : {hold_n, 8'h00};
		q_cmd.row        = reg_row0(region_q) + row_q;
		q_cmd.col        = reg_col0(region_q) + {grp_q[3:0], 3'b000};
		q_cmd.kind       = frame_kind;
		q_cmd.len        = count_n;
		q_cmd.cks        = cks_n;
		q_cmd.fnum       = frame_number;
		q_cmd.ovf        = ovf_n;
		q_push           = acc && (emit || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pos_q    <= '0;
			hold_q   <= '0;
			cks_q    <= '0;
			region_q <= '0;
			row_q    <= '0;
			grp_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (acc) begin
			if (last_byte) begin
				count_q  <= '0;
				pos_q    <= '0;
				hold_q   <= '0;
				cks_q    <= '0;
				region_q <= '0;
				row_q    <= '0;
				grp_q    <= '0;
				ovf_q    <= 1'b0;
			end else begin
				count_q  <= count_n;
				pos_q    <= pos_n;
				hold_q   <= hold_n;
				cks_q    <= cks_n;
				region_q <= region_n;
				row_q    <= row_n;
				grp_q    <= grp_n;
				ovf_q    <= ovf_n;
			end
		end
	end

endmodule

/* rtl/cfse_queue.sv */
// ----------------------------------------------------------------------------
// cfse_queue: short command queue
// Register FIFO between front and back; the head is visible without a read.
// ----------------------------------------------------------------------------
module cfse_queue import cfse_pkg::*; #(
	parameter int DEPTH = CMD_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cfse_cmd_t push_cmd,
	input  logic      pop,
	output logic      full,
	output logic      empty,
	output cfse_cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	cfse_cmd_t         mem_q [DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     cnt_q;
	logic              do_push, do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/cfse_back.sv */
// ----------------------------------------------------------------------------
// cfse_back: cell write sequencer
// Expands each command into its group cells and header cells, one per cycle
// unless a held output stage stalls it, into a registered output stage.
// ----------------------------------------------------------------------------
module cfse_back import cfse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  cfse_cmd_t head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output logic [6:0] pixel_row,
	output logic [6:0] pixel_col,
	output logic [2:0] color_index,
	output logic      run_last,
	output logic      overflow
);

	logic        hdr_q;
	logic [3:0]  k_q;
	logic        valid_q;
	logic [6:0]  row_q, col_q;
	logic [2:0]  color_q;
	logic        last_q, ovf_q;

	logic        ld, step, in_hdr, phase_end;
	logic [6:0]  row_c, col_c;
	logic [2:0]  color_c;
	logic [23:0] hcode;

	assign ld     = !valid_q || out_ready;
	assign step   = ld && !q_empty;
	assign in_hdr = hdr_q || !head.has_group;
	assign hcode  = {head.cks, head.fnum};

	always_comb begin
		if (in_hdr) begin
			row_c     = HEADER_ROW;
			col_c     = HEADER_COL + 7'(k_q);
			phase_end = k_q == 4'd15;
			if (k_q < 4'd4) begin
				color_c = flag_color(head.kind, k_q[1:0]);
			end else if (k_q < 4'd8) begin
				color_c = 3'(head.len >> (4'(k_q[1:0]) * 4'd3));
			end else begin
				color_c = 3'(hcode >> (5'(k_q[2:0]) * 5'd3));
			end
		end else begin
			row_c     = head.row;
			col_c     = head.col + 7'(k_q[2:0]);
			phase_end = k_q == 4'd7;
			color_c   = 3'(head.code >> (5'(k_q[2:0]) * 5'd3));
		end
		q_pop = step && phase_end && (in_hdr || !head.has_header);
	end

	always_ff @(posedge clk) begin
		if (step) begin
			row_q   <= row_c;
			col_q   <= col_c;
			color_q <= color_c;
			last_q  <= q_pop;
			ovf_q   <= head.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= 1'b0;
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			if (ld) begin
				valid_q <= !q_empty;
			end
			if (step) begin
				if (q_pop) begin
					hdr_q <= 1'b0;
					k_q   <= '0;
				end else if (phase_end) begin
					hdr_q <= 1'b1;
					k_q   <= '0;
				end else begin
					k_q <= k_q + 4'd1;
				end
			end
		end
	end

	assign out_valid   = valid_q;
	assign pixel_row   = row_q;
	assign pixel_col   = col_q;
	assign color_index = color_q;
	assign run_last    = last_q;
	assign overflow    = ovf_q;

endmodule

/* rtl/color_frame_symbol_encoder_top.sv */
// ----------------------------------------------------------------------------
// color_frame_symbol_encoder_top: colour-code frame symbol encoder
// Turns the payload bytes of one frame into 3-bit colour cell writes and
// closes each frame with its header row.
// ----------------------------------------------------------------------------
// Path: the first cell of an item passes the command queue, then the output
//   register, before it shows on the master side.
// Throughput: one cell write per cycle from the back sequencer while commands
//   wait and m_tready does not stall it; a group of three bytes makes eight cell
//   writes, and the last byte adds 16 header cells, 24 at most. Bytes enter one
//   per cycle while the command queue has room.
// Reset: arst_n clears frame state, the queue and the output valid at once.
module color_frame_symbol_encoder_top import cfse_pkg::*; #(
	parameter int FRAME_BYTES = FRAME_BYTES_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] data_byte, [15:8] frame_number
	input  logic        s_tlast,  // last_byte
	input  logic [1:0]  s_tuser,  // [1:0] frame_kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [6:0] pixel_row, [13:7] pixel_col, [16:14] color_index
	output logic        m_tlast,  // run_last
	output logic        m_tuser   // overflow
);

	logic      q_push, q_pop, q_full, q_empty;
	cfse_cmd_t q_cmd, q_head;
	logic [6:0] pixel_row, pixel_col;
	logic [2:0] color_index;

	// front: pack bytes, track checksum and region position, issue commands
	cfse_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.data_byte   (s_tdata[7:0]),
		.last_byte   (s_tlast),
		.frame_kind  (s_tuser),
		.frame_number(s_tdata[15:8]),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	// decouple intake from the cell sequencer
	cfse_queue #(
		.DEPTH(CMD_QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.pop     (q_pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (q_head)
	);

	// back: one cell write per cycle into the output register while m_tready does not stall it
	cfse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (q_head),
		.q_pop      (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.pixel_row  (pixel_row),
		.pixel_col  (pixel_col),
		.color_index(color_index),
		.run_last   (m_tlast),
		.overflow   (m_tuser)
	);

	assign m_tdata = {7'b0, color_index, pixel_col, pixel_row};

endmodule

/* tb/color_cell_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_cell_checker: predicts and checks the cell writes of the frame encoder
// Watches the byte channel and the cell channel, keeps a model of the frame
// state, queues the cell writes each accepted byte must cause and compares
// every accepted cell write with the oldest one still due.
// ----------------------------------------------------------------------------
module color_cell_checker import cfse_pkg::*; #(
	parameter int FRAME_CAP = FRAME_BYTES_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] data_byte, [15:8] frame_number
	input  logic        s_tlast,  // last_byte
	input  logic [1:0]  s_tuser,  // [1:0] frame_kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // [6:0] pixel_row, [13:7] pixel_col, [16:14] color_index
	input  logic        m_tlast,  // run_last
	input  logic        m_tuser,  // overflow
	output int          mismatch_count,
	output int          cells_pending
);

	typedef struct packed {
		logic [6:0] row;
		logic [6:0] col;
		logic [2:0] color;
		logic       last;
		logic       ovf;
	} cell_t;

	// region geometry, region 0 in the lowest slot
	localparam logic [6:0][6:0] ZONE_ROWS  = {7'd8, 7'd8, 7'd16, 7'd72, 7'd72, 7'd16, 7'd71};
	localparam logic [6:0][3:0] ZONE_SLOTS = {4'd1, 4'd2, 4'd9, 4'd2, 4'd9, 4'd9, 4'd2};
	localparam logic [6:0][6:0] ZONE_TOP   = {7'd98, 7'd90, 7'd90, 7'd18, 7'd18, 7'd2, 7'd19};
	localparam logic [6:0][6:0] ZONE_LEFT  = {7'd90, 7'd90, 7'd18, 7'd90, 7'd18, 7'd18, 7'd2};

	cell_t       cells_due[$];
	logic [11:0] bytes_taken;
	logic [15:0] held;
	logic [15:0] xor_sum;
	logic [2:0]  zone;
	logic [6:0]  zone_row;
	logic [3:0]  zone_slot;
	logic        dropped;
	int          fails;

	function automatic void clear_frame();
		bytes_taken = '0;
		held        = '0;
		xor_sum     = '0;
		zone        = '0;
		zone_row    = '0;
		zone_slot   = '0;
		dropped     = 1'b0;
	endfunction

	function automatic void add_cell(input logic [6:0] row, input logic [6:0] col,
		input logic [2:0] color);
		cell_t c;
		c.row   = row;
		c.col   = col;
		c.color = color;
		c.last  = 1'b0;
		c.ovf   = dropped;
		cells_due.push_back(c);
	endfunction

	function automatic logic [3:0] flag_pattern(input logic [1:0] kind);
		logic [3:0] pat;
		case (kind)
			KIND_START:     pat = 4'b0011;
			KIND_END:       pat = 4'b1100;
			KIND_START_END: pat = 4'b1111;
			KIND_NORMAL:    pat = 4'b0000;
			default:        pat = 4'b0000;
		endcase
		return pat;
	endfunction

	// write one 24-bit group into the next eight cells, then advance the cursor
	function automatic void place_group(input logic [23:0] code);
		logic [6:0] row;
		logic [6:0] col;
		logic [6:0] slot_off;
		if (zone < NUM_REGIONS) begin
			row      = ZONE_TOP[zone] + zone_row;
			slot_off = {zone_slot, 3'b000};
			for (int k = 0; k < 8; k++) begin
				col = ZONE_LEFT[zone] + slot_off + k[6:0];
				add_cell(row, col, code[3*k +: 3]);
			end
			zone_slot = zone_slot + 4'd1;
			if (zone_slot >= ZONE_SLOTS[zone]) begin
				zone_slot = '0;
				zone_row  = zone_row + 7'd1;
				if (zone_row >= ZONE_ROWS[zone]) begin
					zone_row = '0;
					zone     = zone + 3'd1;
				end
			end
		end
	endfunction

	function automatic void predict_item(input logic [7:0] data, input logic last,
		input logic [1:0] kind, input logic [7:0] fnum);
		int          start;
		int          pos;
		logic [3:0]  pat;
		logic [23:0] tail;
		cell_t       c;
		start = cells_due.size();
		if (bytes_taken < FRAME_CAP) begin
			pos = bytes_taken % 3;
			if (bytes_taken[0])
				xor_sum = xor_sum ^ {8'h00, data};
			else
				xor_sum = xor_sum ^ {data, 8'h00};
			bytes_taken = bytes_taken + 12'd1;
			if (pos == 0) begin
				held = {data, 8'h00};
			end else if (pos == 1) begin
				held[7:0] = data;
			end else begin
				place_group({held, data});
				held = '0;
			end
		end else begin
			// no room left: drop the byte but remember it
			dropped = 1'b1;
		end
		if (last) begin
			if (bytes_taken % 3 != 0)
				place_group({held, 8'h00});
			pat = flag_pattern(kind);
			for (int i = 0; i < 4; i++)
				add_cell(HEADER_ROW, HEADER_COL + i[6:0], pat[i] ? COLOR_WHITE : COLOR_BLACK);
			for (int i = 0; i < 4; i++)
				add_cell(HEADER_ROW, HEADER_COL + 7'd4 + i[6:0], bytes_taken[3*i +: 3]);
			tail = {xor_sum, fnum};
			for (int i = 0; i < 8; i++)
				add_cell(HEADER_ROW, HEADER_COL + 7'd8 + i[6:0], tail[3*i +: 3]);
			clear_frame();
		end
		if (cells_due.size() > start) begin
			c = cells_due.pop_back();
			c.last = 1'b1;
			cells_due.push_back(c);
		end
	endfunction

	function automatic void check_write();
		cell_t want;
		if (cells_due.size() == 0) begin
			$error("unexpected cell write: row %0d col %0d color %0d",
				m_tdata[6:0], m_tdata[13:7], m_tdata[16:14]);
			fails++;
		end else begin
			want = cells_due.pop_front();
			if (m_tdata[6:0] !== want.row) begin
				$error("pixel_row: expected %0d, got %0d", want.row, m_tdata[6:0]);
				fails++;
			end
			if (m_tdata[13:7] !== want.col) begin
				$error("pixel_col: expected %0d, got %0d", want.col, m_tdata[13:7]);
				fails++;
			end
			if (m_tdata[16:14] !== want.color) begin
				$error("color_index: expected %0d, got %0d", want.color, m_tdata[16:14]);
				fails++;
			end
			if (m_tlast !== want.last) begin
				$error("run_last: expected %0d, got %0d", want.last, m_tlast);
				fails++;
			end
			if (m_tuser !== want.ovf) begin
				$error("overflow: expected %0d, got %0d", want.ovf, m_tuser);
				fails++;
			end
		end
	endfunction

	// retire the output first so a byte taken at the same edge cannot feed it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			cells_due.delete();
			fails = 0;
			mismatch_count <= 0;
			cells_pending  <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_write();
			if (s_tvalid && s_tready)
				predict_item(s_tdata[7:0], s_tlast, s_tuser, s_tdata[15:8]);
			mismatch_count <= fails;
			cells_pending  <= cells_due.size();
		end
	end

endmodule

/* tb/color_frame_symbol_encoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_frame_symbol_encoder_top_tb: frame symbol encoder testbench
// Feeds payload bytes framed by tlast, first a few hand-picked frames, then
// random frames under four idling patterns; the checker predicts every cell
// write and flags any difference.
// ----------------------------------------------------------------------------
module color_frame_symbol_encoder_top_tb;
	import cfse_pkg::*;

	// Cycle bound far above the slowest correct run.
	localparam int CYCLE_LIMIT = 2_000_000;
	// Cycles to keep watching after the last cell write is due: covers the
	// command queue and output register plus a full header burst.
	localparam int TAIL_CYCLES = 40;
	localparam int PHASE_BYTES = 60;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;  // [7:0] data_byte, [15:8] frame_number
	logic        s_tlast  = 1'b0;  // last_byte
	logic [1:0]  s_tuser  = '0;  // [1:0] frame_kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;  // [6:0] pixel_row, [13:7] pixel_col, [16:14] color_index
	logic        m_tlast;  // run_last
	logic        m_tuser;  // overflow

	int mismatch_count;
	int cells_pending;
	int idle_pct  = 0;
	int stall_pct = 0;
	int cycles    = 0;

	color_frame_symbol_encoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	color_cell_checker #(.FRAME_CAP(FRAME_BYTES_MAX)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.cells_pending  (cells_pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hold reset at the start, then release it for good
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: stall at random at the rate of the current phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog: stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Offer one item and hold it until taken. Valid stays high into the next
	// call, so back-to-back items never drop it.
	task automatic send_byte(input logic [7:0] data, input logic last,
		input logic [1:0] kind, input logic [7:0] fnum);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {fnum, data};
		s_tlast  <= last;
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Random payload; kind and frame number are noise on every byte but the last.
	task automatic send_frame(input int len, input logic [1:0] kind, input logic [7:0] fnum);
		for (int i = 0; i < len; i++) begin
			if (i == len - 1)
				send_byte(8'($urandom_range(255)), 1'b1, kind, fnum);
			else
				send_byte(8'($urandom_range(255)), 1'b0, 2'($urandom_range(3)),
					8'($urandom_range(255)));
		end
	endtask

	// Drop valid and hold off until every predicted cell write has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (cells_pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sent;
		int len;
		wait (arst_n);
		@(posedge clk);

		// Hand-picked frames: a padded group of one byte, a lone byte,
		// no padding, all four kinds, extreme byte and frame-number values.
		send_byte(8'h00, 1'b0, KIND_NORMAL, 8'h00);
		send_byte(8'hFF, 1'b0, KIND_NORMAL, 8'hFF);
		send_byte(8'hA5, 1'b0, KIND_START, 8'h00);
		send_byte(8'h5A, 1'b1, KIND_START, 8'h00);
		send_byte(8'hFF, 1'b1, KIND_END, 8'hFF);
		send_byte(8'h80, 1'b0, KIND_END, 8'h01);
		send_byte(8'h01, 1'b1, KIND_START_END, 8'h80);
		send_byte(8'h7F, 1'b0, KIND_START, 8'hAA);
		send_byte(8'hFE, 1'b0, KIND_END, 8'h55);
		send_byte(8'h01, 1'b1, KIND_NORMAL, 8'h7F);
		for (int i = 0; i < 5; i++)
			send_byte(8'hFF, 1'b0, KIND_START_END, 8'hFF);
		send_byte(8'h00, 1'b1, KIND_NORMAL, 8'h55);
		drain();

		// Random frames, mostly short, under each idling pattern.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 84; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 84; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			sent = 0;
			while (sent < PHASE_BYTES) begin
				if ($urandom_range(3) == 0)
					len = int'($urandom_range(30, 13));
				else
					len = int'($urandom_range(12, 1));
				send_frame(len, 2'($urandom_range(3)), 8'($urandom_range(255)));
				sent += len;
			end
			drain();
		end

		if (mismatch_count == 0 && cells_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* color_frame_symbol_encoder_top.f */
rtl/cfse_pkg.sv
rtl/cfse_front.sv
rtl/cfse_queue.sv
rtl/cfse_back.sv
rtl/color_frame_symbol_encoder_top.sv
tb/color_cell_checker.sv
tb/color_frame_symbol_encoder_top_tb.sv
